// ----- rtl/core/gmd_pkg.sv -----
// ----------------------------------------------------------------------------
// gmd_pkg
// Shared widths, codes, types and the sensitivity threshold table of the
// gyro motion detector.
// ----------------------------------------------------------------------------
package gmd_pkg;

   localparam int RAW_W   = 16;
   localparam int COMP_W  = 27;
   localparam int OUT_W   = 26;
   localparam int BIAS_W  = 34;
   localparam int PROD_W  = 38;
   localparam int SQ_W    = 53;
   localparam int SUM_W   = 54;
   localparam int ROOT_W  = 27;
   localparam int REM_W   = 28;
   localparam int CNT_W   = 5;
   localparam int TIME_W  = 32;
   localparam int CONF_W  = 22;
   localparam int IVL_W   = 16;
   localparam int LVL_W   = 3;
   localparam int THR_W   = 19;
   localparam int AVG_W   = 26;
   localparam int NLANES  = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 22;

   localparam logic signed [10:0] ALPHA_Q16 = 11'sd655;

   localparam logic [LVL_W-1:0]  LEVEL_RST    = 3'd3;
   localparam logic [IVL_W-1:0]  INTERVAL_RST = 16'd40;
   localparam logic [CONF_W-1:0] MCONF_RST    = 22'd2000;
   localparam logic [CONF_W-1:0] ICONF_RST    = 22'd30000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LEVEL    = 2'd0,
      CSR_INTERVAL = 2'd1,
      CSR_MCONF    = 2'd2,
      CSR_ICONF    = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_COMP,
      ST_SQUARE,
      ST_SUM,
      ST_ROOT,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic seed;
      logic comp_en;
      logic sq_en;
      logic bias_en;
   } lane_ctrl_type;

   typedef struct packed {
      logic take;     // sample passed the interval check
      logic sum_en;
      logic update;
   } merge_ctrl_type;

   typedef struct packed {
      logic [AVG_W-1:0]  avg;
      logic              moving;
      logic              stationary;
      logic [CONF_W-1:0] remaining;
      logic [TIME_W-1:0] last_motion;
   } det_state_type;

   function automatic logic [THR_W-1:0] threshold(input logic [LVL_W-1:0] level);
      logic [THR_W-1:0] thr;
      unique case (level)
         3'd1:    thr = 19'd58514;
         3'd2:    thr = 19'd117029;
         3'd4:    thr = 19'd292571;
         3'd5:    thr = 19'd438857;
         default: thr = 19'd175543;
      endcase
      return thr;
   endfunction

endpackage

// ----- rtl/core/gmd_if.sv -----
// ----------------------------------------------------------------------------
// gmd channel interfaces
// Sample, result and register write channels with valid/ready transfer.
// ----------------------------------------------------------------------------
interface gmd_req_if import gmd_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [RAW_W-1:0]  raw_x;
   logic signed [RAW_W-1:0]  raw_y;
   logic signed [RAW_W-1:0]  raw_z;
   logic [TIME_W-1:0]        now_ms;
   modport source (output valid, raw_x, raw_y, raw_z, now_ms, input ready);
   modport sink   (input valid, raw_x, raw_y, raw_z, now_ms, output ready);
endinterface

interface gmd_rsp_if import gmd_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     accepted;
   logic signed [OUT_W-1:0]  comp_x;
   logic signed [OUT_W-1:0]  comp_y;
   logic signed [OUT_W-1:0]  comp_z;
   logic [AVG_W-1:0]         motion_level;
   logic                     moving;
   logic                     stationary_confirmed;
   logic [CONF_W-1:0]        confirm_remaining_ms;
   logic [TIME_W-1:0]        last_motion_ms;
   modport source (output valid, accepted, comp_x, comp_y, comp_z, motion_level, moving,
                   stationary_confirmed, confirm_remaining_ms, last_motion_ms,
                   input ready);
   modport sink   (input valid, accepted, comp_x, comp_y, comp_z, motion_level, moving,
                   stationary_confirmed, confirm_remaining_ms, last_motion_ms,
                   output ready);
endinterface

interface gmd_csr_if import gmd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/gmd_lane.sv -----
// ----------------------------------------------------------------------------
// gmd_lane
// One axis: holds the Q18.16 bias, forms the compensated rate, its square
// and the adapted bias.
// ----------------------------------------------------------------------------
module gmd_lane import gmd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  lane_ctrl_type            ctrl,
   input  logic signed [RAW_W-1:0]  raw,
   output logic signed [COMP_W-1:0] comp,
   output logic [SQ_W-1:0]          sq
);
   logic signed [BIAS_W-1:0]   bias_ff, bias_in;
   logic signed [COMP_W-1:0]   comp_ff, comp_in;
   logic [SQ_W-1:0]            sq_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [2*COMP_W-1:0] sq_full;
   logic signed [PROD_W-1:0]   prod_full;
   logic signed [COMP_W-1:0]   raw_q8;
   logic signed [COMP_W-1:0]   bias_q8;
   logic signed [BIAS_W-1:0]   step;

   assign raw_q8  = {{(COMP_W-RAW_W-8){raw[RAW_W-1]}}, raw, 8'd0};
   assign bias_q8 = {bias_ff[BIAS_W-1], bias_ff[BIAS_W-1:8]};
   assign comp_in = raw_q8 - bias_q8;

   assign sq_full   = comp_ff * comp_ff;
   assign prod_full = PROD_W'(comp_ff * ALPHA_Q16);
   // floor divide by 256, then sign-extend into the bias width
   assign step      = {{(BIAS_W-PROD_W+8){prod_ff[PROD_W-1]}}, prod_ff[PROD_W-1:8]};

   always_comb begin
      bias_in = bias_ff;
      if (ctrl.seed) begin
         bias_in = {{(BIAS_W-RAW_W-16){raw[RAW_W-1]}}, raw, 16'd0};
      end else if (ctrl.bias_en) begin
         bias_in = bias_ff + step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_ff <= '0;
      end else begin
         bias_ff <= bias_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.comp_en) begin
         comp_ff <= comp_in;
      end
      if (ctrl.sq_en) begin
         sq_ff   <= sq_full[SQ_W-1:0];
         prod_ff <= prod_full;
      end
   end

   assign comp = comp_ff;
   assign sq   = sq_ff;
endmodule

// ----- rtl/core/gmd_isqrt.sv -----
// ----------------------------------------------------------------------------
// gmd_isqrt
// Floor square root, one result bit per cycle (restoring, two radicand bits
// a step).
// ----------------------------------------------------------------------------
module gmd_isqrt import gmd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SUM_W-1:0]  value,
   output logic              done,
   output logic [ROOT_W-1:0] root
);
   logic [SUM_W-1:0]  val_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              done_ff, done_in;
   logic [REM_W+1:0]  rem_sh;
   logic [REM_W+1:0]  trial;
   logic              fit;

   assign rem_sh = {rem_ff, val_ff[SUM_W-1 -: 2]};
   assign trial  = {1'b0, root_ff, 2'b01};
   assign fit    = rem_sh >= trial;

   always_comb begin
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         cnt_in = CNT_W'(ROOT_W);
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         val_ff  <= value;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (cnt_ff != '0) begin
         val_ff  <= {val_ff[SUM_W-3:0], 2'b00};
         rem_ff  <= fit ? REM_W'(rem_sh - trial) : rem_sh[REM_W-1:0];
         root_ff <= {root_ff[ROOT_W-2:0], fit};
      end
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule

// ----- rtl/core/gmd_merge.sv -----
// ----------------------------------------------------------------------------
// gmd_merge
// Combines the lane squares, smooths the magnitude and runs the
// movement / stationary decision.
// ----------------------------------------------------------------------------
module gmd_merge import gmd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  merge_ctrl_type    ctrl,
   input  logic [TIME_W-1:0] now,
   input  logic [SQ_W-1:0]   sq_x,
   input  logic [SQ_W-1:0]   sq_y,
   input  logic [SQ_W-1:0]   sq_z,
   input  logic [ROOT_W-1:0] mag,
   input  logic [LVL_W-1:0]  level,
   input  logic [IVL_W-1:0]  interval,
   input  logic [CONF_W-1:0] mconf,
   input  logic [CONF_W-1:0] iconf,
   output logic              skip,
   output logic              need_seed,
   output logic              bias_adapt,
   output logic [SUM_W-1:0]  sum,
   output det_state_type     det
);
   logic [SUM_W-1:0]  sum_ff;
   logic              bias_ready_ff, bias_ready_in;
   logic [TIME_W-1:0] last_time_ff, last_time_in;
   logic              last_valid_ff, last_valid_in;
   logic [AVG_W-1:0]  avg_ff, avg_in;
   logic              moving_ff, moving_in;
   logic              stat_ff, stat_in;
   logic [TIME_W-1:0] above_ff, above_in;
   logic              above_valid_ff, above_valid_in;
   logic [TIME_W-1:0] calm_ff, calm_in;
   logic              calm_valid_ff, calm_valid_in;
   logic [TIME_W-1:0] motion_ff, motion_in;

   logic [THR_W-1:0]  thr;
   logic [AVG_W+2:0]  avg_acc;
   logic [AVG_W+3:0]  avg10;
   logic [THR_W+2:0]  thr7;
   logic [TIME_W-1:0] above_t, calm_t, el;

   assign thr        = threshold(level);
   assign skip       = last_valid_ff && ((now - last_time_ff) < TIME_W'(interval));
   assign need_seed  = !bias_ready_ff;
   assign bias_adapt = !moving_ff && ({1'b0, mag, 1'b0} < (ROOT_W+2)'(thr));
   assign avg_acc    = (AVG_W+3)'({avg_ff, 1'b0}) + (AVG_W+3)'(avg_ff) + (AVG_W+3)'(mag);
   assign avg10      = (AVG_W+4)'({avg_in, 3'b000}) + (AVG_W+4)'({avg_in, 1'b0});
   assign thr7       = (THR_W+3)'({thr, 3'b000}) - (THR_W+3)'(thr);

   always_comb begin
      bias_ready_in  = bias_ready_ff;
      last_time_in   = last_time_ff;
      last_valid_in  = last_valid_ff;
      avg_in         = avg_ff;
      moving_in      = moving_ff;
      stat_in        = stat_ff;
      above_in       = above_ff;
      above_valid_in = above_valid_ff;
      calm_in        = calm_ff;
      calm_valid_in  = calm_valid_ff;
      motion_in      = motion_ff;
      above_t        = now;
      calm_t         = now;
      if (ctrl.take) begin
         last_time_in  = now;
         last_valid_in = 1'b1;
         if (!bias_ready_ff) begin
            bias_ready_in  = 1'b1;
            moving_in      = 1'b0;
            stat_in        = 1'b0;
            motion_in      = now;
            calm_in        = now;
            calm_valid_in  = 1'b1;
            above_valid_in = 1'b0;
         end
      end else if (ctrl.update) begin
         avg_in  = avg_acc[AVG_W+1:2];
         above_t = above_valid_ff ? above_ff : now;
         calm_t  = calm_valid_ff ? calm_ff : now;
         if ((THR_W+7)'(avg_in) >= (THR_W+7)'(thr)) begin
            above_in       = above_t;
            above_valid_in = 1'b1;
            if (stat_ff || ((now - above_t) >= TIME_W'(mconf))) begin
               moving_in     = 1'b1;
               stat_in       = 1'b0;
               motion_in     = now;
               calm_valid_in = 1'b0;
            end
         end else if (moving_ff ? (avg10 <= (AVG_W+4)'(thr7)) : !stat_ff) begin
            // calm: start or continue the stationary count
            above_valid_in = 1'b0;
            calm_in        = calm_t;
            calm_valid_in  = 1'b1;
            if ((now - calm_t) >= TIME_W'(iconf)) begin
               moving_in = 1'b0;
               stat_in   = 1'b1;
            end
         end else if (!moving_ff) begin
            above_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_ready_ff  <= 1'b0;
         last_time_ff   <= '0;
         last_valid_ff  <= 1'b0;
         avg_ff         <= '0;
         moving_ff      <= 1'b0;
         stat_ff        <= 1'b0;
         above_ff       <= '0;
         above_valid_ff <= 1'b0;
         calm_ff        <= '0;
         calm_valid_ff  <= 1'b0;
         motion_ff      <= '0;
      end else begin
         bias_ready_ff  <= bias_ready_in;
         last_time_ff   <= last_time_in;
         last_valid_ff  <= last_valid_in;
         avg_ff         <= avg_in;
         moving_ff      <= moving_in;
         stat_ff        <= stat_in;
         above_ff       <= above_in;
         above_valid_ff <= above_valid_in;
         calm_ff        <= calm_in;
         calm_valid_ff  <= calm_valid_in;
         motion_ff      <= motion_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.sum_en) begin
         sum_ff <= SUM_W'(sq_x) + SUM_W'(sq_y) + SUM_W'(sq_z);
      end
   end

   assign el = now - calm_ff;

   always_comb begin
      det.avg         = avg_ff;
      det.moving      = moving_ff;
      det.stationary  = stat_ff;
      det.last_motion = motion_ff;
      if (stat_ff || !calm_valid_ff || (el >= TIME_W'(iconf))) begin
         det.remaining = '0;
      end else begin
         det.remaining = iconf - el[CONF_W-1:0];
      end
   end

   assign sum = sum_ff;
endmodule

// ----- rtl/core/gyro_motion_detector_core.sv -----
// ----------------------------------------------------------------------------
// gyro_motion_detector_core
// Bias-compensated gyro magnitude with movement and stationary detection.
// ----------------------------------------------------------------------------
// One sample is in work at a time. For a sample that passes the interval
// check, the three axis lanes form the compensated rates and their squares
// in parallel, and the floor square root of the summed squares then runs
// one root bit per cycle, which sets the rate while results are taken. A
// skipped sample goes from the check straight to the finish state. The next
// sample is taken while a result still waits on rsp_bus. Register writes
// are always ready and are meant for idle periods.
module gyro_motion_detector_core import gmd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   gmd_req_if.sink   req_bus,
   gmd_rsp_if.source rsp_bus,
   gmd_csr_if.sink   csr_bus
);
   state_type state_ff, state_in;

   logic [LVL_W-1:0]  level_ff;
   logic [IVL_W-1:0]  interval_ff;
   logic [CONF_W-1:0] mconf_ff;
   logic [CONF_W-1:0] iconf_ff;

   logic signed [RAW_W-1:0] raw_ff [NLANES];
   logic [TIME_W-1:0]       now_ff;

   lane_ctrl_type           lane_ctrl;
   merge_ctrl_type          merge_ctrl;
   logic signed [COMP_W-1:0] comp [NLANES];
   logic [SQ_W-1:0]          sq [NLANES];
   logic                    sqrt_done;
   logic [ROOT_W-1:0]       root;
   logic [SUM_W-1:0]        sum;
   logic                    skip, need_seed, bias_adapt;
   det_state_type           det;

   logic                    req_take, rsp_load;
   logic                    accepted_ff, accepted_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   assign req_take      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff    <= LEVEL_RST;
         interval_ff <= INTERVAL_RST;
         mconf_ff    <= MCONF_RST;
         iconf_ff    <= ICONF_RST;
      end else if (csr_bus.valid) begin
         unique case (csr_index_type'(csr_bus.index))
            CSR_LEVEL:    level_ff    <= csr_bus.data[LVL_W-1:0];
            CSR_INTERVAL: interval_ff <= csr_bus.data[IVL_W-1:0];
            CSR_MCONF:    mconf_ff    <= csr_bus.data;
            CSR_ICONF:    iconf_ff    <= csr_bus.data;
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         raw_ff[0] <= req_bus.raw_x;
         raw_ff[1] <= req_bus.raw_y;
         raw_ff[2] <= req_bus.raw_z;
         now_ff    <= req_bus.now_ms;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_take) state_in = ST_CHECK;
         ST_CHECK:  state_in = skip ? ST_FINISH : ST_COMP;
         ST_COMP:   state_in = ST_SQUARE;
         ST_SQUARE: state_in = ST_SUM;
         ST_SUM:    state_in = ST_ROOT;
         ST_ROOT:   if (sqrt_done) state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_FINISH;
         ST_FINISH: if (rsp_load) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      lane_ctrl      = '0;
      merge_ctrl     = '0;
      rsp_load       = 1'b0;
      req_bus.ready  = 1'b0;
      accepted_in    = accepted_ff;
      unique case (state_ff)
         ST_IDLE:   req_bus.ready = 1'b1;
         ST_CHECK: begin
            accepted_in     = !skip;
            merge_ctrl.take = !skip;
            lane_ctrl.seed  = !skip && need_seed;
         end
         ST_COMP:   lane_ctrl.comp_en = 1'b1;
         ST_SQUARE: lane_ctrl.sq_en = 1'b1;
         ST_SUM:    merge_ctrl.sum_en = 1'b1;
         ST_ROOT:   ;
         ST_UPDATE: begin
            merge_ctrl.update = 1'b1;
            lane_ctrl.bias_en = bias_adapt;
         end
         ST_FINISH: rsp_load = !rsp_valid_ff || rsp_bus.ready;
         default:   ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         accepted_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         accepted_ff  <= accepted_in;
      end
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_bus.ready);

   // square root starts once the sum register holds the new value
   logic root_go_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         root_go_ff <= 1'b0;
      end else begin
         root_go_ff <= merge_ctrl.sum_en;
      end
   end

   for (genvar i = 0; i < NLANES; i++) begin : g_lane
      gmd_lane u_lane (
         .clock (clock),
         .reset (reset),
         .ctrl  (lane_ctrl),
         .raw   (raw_ff[i]),
         .comp  (comp[i]),
         .sq    (sq[i])
      );
   end

   gmd_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (root_go_ff),
      .value (sum),
      .done  (sqrt_done),
      .root  (root)
   );

   gmd_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (merge_ctrl),
      .now        (now_ff),
      .sq_x       (sq[0]),
      .sq_y       (sq[1]),
      .sq_z       (sq[2]),
      .mag        (root),
      .level      (level_ff),
      .interval   (interval_ff),
      .mconf      (mconf_ff),
      .iconf      (iconf_ff),
      .skip       (skip),
      .need_seed  (need_seed),
      .bias_adapt (bias_adapt),
      .sum        (sum),
      .det        (det)
   );

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_bus.accepted             <= accepted_ff;
         rsp_bus.comp_x               <= accepted_ff ? comp[0][OUT_W-1:0] : '0;
         rsp_bus.comp_y               <= accepted_ff ? comp[1][OUT_W-1:0] : '0;
         rsp_bus.comp_z               <= accepted_ff ? comp[2][OUT_W-1:0] : '0;
         rsp_bus.motion_level         <= det.avg;
         rsp_bus.moving               <= det.moving;
         rsp_bus.stationary_confirmed <= det.stationary;
         rsp_bus.confirm_remaining_ms <= det.remaining;
         rsp_bus.last_motion_ms       <= det.last_motion;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
endmodule

// ----- rtl/core/gmd_checker.sv -----
// ----------------------------------------------------------------------------
// gmd_checker
// Port-level checks of the gyro motion detector result channel.
// ----------------------------------------------------------------------------
module gmd_checker import gmd_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              accepted,
   input logic [OUT_W-1:0]  comp_x,
   input logic [OUT_W-1:0]  comp_y,
   input logic [OUT_W-1:0]  comp_z,
   input logic              moving,
   input logic              stationary,
   input logic [CONF_W-1:0] remaining
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

   a_skip_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !accepted |-> comp_x == '0 && comp_y == '0 && comp_z == '0)
      else $error("skipped sample carries rates");

   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(moving && stationary))
      else $error("moving and stationary together");

   a_stat_no_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && stationary |-> remaining == '0)
      else $error("count running while stationary");
endmodule

bind gyro_motion_detector_core gmd_checker u_gmd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .accepted   (rsp_bus.accepted),
   .comp_x     (rsp_bus.comp_x),
   .comp_y     (rsp_bus.comp_y),
   .comp_z     (rsp_bus.comp_z),
   .moving     (rsp_bus.moving),
   .stationary (rsp_bus.stationary_confirmed),
   .remaining  (rsp_bus.confirm_remaining_ms)
);
